// File: rtl/cwa_pkg.sv
package cwa_pkg;

   // Window length and field widths
   localparam int WINDOW   = 10;
   localparam int SAMPLE_W = 16;
   localparam int CLOG_W   = $clog2(WINDOW);
   localparam int SUM_W    = SAMPLE_W + CLOG_W;
   localparam int CNT_W    = $clog2(WINDOW + 1);

   // Reciprocal for the divide by WINDOW: exact for every sum below 2**SUM_W
   localparam int DIV_SHIFT = SUM_W + CLOG_W;
   localparam int MULT_W    = SUM_W + 2;
   localparam longint unsigned DIV_MULT =
      ((longint'(1) << DIV_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
   localparam int PROD_W    = SUM_W + MULT_W;

   typedef enum logic [0:0] {
      ST_RUN,
      ST_FLUSH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic flush_step;
      logic pop;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic seen_hi;
      logic flush_last;
      logic out_valid;
   } status_type;

   // Floor of sum / WINDOW by multiplication with the reciprocal
   function automatic logic [SAMPLE_W-1:0] div_window(input logic [SUM_W-1:0] s);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(s) * PROD_W'(DIV_MULT);
      return prod[DIV_SHIFT +: SAMPLE_W];
   endfunction

endpackage

// File: rtl/cwa_ctrl.sv
module cwa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_final_sample,
   input  logic               rsp_stall,
   input  cwa_pkg::status_type status,
   output cwa_pkg::cmd_type   cmd,
   output logic               req_stall
);
   import cwa_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      slot_free;

   // Output register can take a new beat this cycle
   assign slot_free = !status.out_valid || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (req_valid && slot_free && req_final_sample && status.seen_hi) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (slot_free && status.flush_last) begin
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   // Commands
   always_comb begin
      cmd.accept     = 1'b0;
      cmd.flush_step = 1'b0;
      cmd.pop        = !rsp_stall;
      req_stall      = 1'b1;
      case (state_ff)
         ST_RUN: begin
            req_stall  = !slot_free;
            cmd.accept = req_valid && slot_free;
         end
         ST_FLUSH: begin
            cmd.flush_step = slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   // No sample taken while the wrapped results drain
   a_no_accept_in_flush: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |-> !cmd.accept)
      else $error("sample accepted during flush");

endmodule

// File: rtl/cwa_datapath.sv
module cwa_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  cwa_pkg::cmd_type               cmd,
   input  logic [cwa_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                           req_final_sample,
   output cwa_pkg::status_type            status,
   output logic                           rsp_valid,
   output logic [cwa_pkg::SAMPLE_W-1:0]   rsp_average,
   output logic                           rsp_end_of_run,
   output logic                           rsp_too_short
);
   import cwa_pkg::*;

   logic [SAMPLE_W-1:0] line_ff [WINDOW];
   logic [SAMPLE_W-1:0] line_in [WINDOW];
   logic [SAMPLE_W-1:0] head_ff [WINDOW-1];
   logic [SAMPLE_W-1:0] head_in [WINDOW-1];
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    seen_ff, seen_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                valid_ff, valid_in;
   logic [SAMPLE_W-1:0] avg_ff, avg_in;
   logic                eor_ff, eor_in;
   logic                short_ff, short_in;
   logic [SUM_W-1:0]    new_sum;
   logic [SUM_W-1:0]    flush_sum;
   logic                seen_hi;
   logic                flush_last;

   assign seen_hi    = seen_ff >= CNT_W'(WINDOW - 1);
   assign flush_last = cnt_ff == CNT_W'(WINDOW - 2);
   assign new_sum    = sum_ff - SUM_W'(line_ff[0]) + SUM_W'(req_sample);
   assign flush_sum  = sum_ff - SUM_W'(line_ff[0]) + SUM_W'(head_ff[0]);

   assign status.seen_hi    = seen_hi;
   assign status.flush_last = flush_last;
   assign status.out_valid  = valid_ff;

   // Window update, head store and output beat
   always_comb begin
      line_in  = line_ff;
      head_in  = head_ff;
      sum_in   = sum_ff;
      seen_in  = seen_ff;
      cnt_in   = cnt_ff;
      avg_in   = avg_ff;
      eor_in   = eor_ff;
      short_in = short_ff;
      valid_in = cmd.pop ? 1'b0 : valid_ff;

      if (cmd.accept) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            line_in[i] = line_ff[i+1];
         end
         line_in[WINDOW-1] = req_sample;
         sum_in  = new_sum;
         seen_in = seen_hi ? CNT_W'(WINDOW) : seen_ff + CNT_W'(1);
         if (!seen_hi) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
               if (seen_ff == CNT_W'(i)) begin
                  head_in[i] = req_sample;
               end
            end
         end
         cnt_in = '0;
         if (seen_hi) begin
            // ordinary window result
            valid_in = 1'b1;
            avg_in   = div_window(new_sum);
            eor_in   = 1'b0;
            short_in = 1'b0;
         end else if (req_final_sample) begin
            // vector shorter than the window
            valid_in = 1'b1;
            avg_in   = '0;
            eor_in   = 1'b1;
            short_in = 1'b1;
            for (int i = 0; i < WINDOW; i++) begin
               line_in[i] = '0;
            end
            sum_in  = '0;
            seen_in = '0;
         end
      end

      if (cmd.flush_step) begin
         valid_in = 1'b1;
         avg_in   = div_window(flush_sum);
         eor_in   = flush_last;
         short_in = 1'b0;
         if (flush_last) begin
            for (int i = 0; i < WINDOW; i++) begin
               line_in[i] = '0;
            end
            sum_in  = '0;
            seen_in = '0;
            cnt_in  = '0;
         end else begin
            // walk both stores so the next pair sits at the front
            for (int i = 0; i < WINDOW - 1; i++) begin
               line_in[i] = line_ff[i+1];
            end
            line_in[WINDOW-1] = '0;
            for (int i = 0; i < WINDOW - 2; i++) begin
               head_in[i] = head_ff[i+1];
            end
            sum_in = flush_sum;
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   // Control state and window
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            line_ff[i] <= '0;
         end
         sum_ff   <= '0;
         seen_ff  <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         line_ff  <= line_in;
         sum_ff   <= sum_in;
         seen_ff  <= seen_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      avg_ff   <= avg_in;
      eor_ff   <= eor_in;
      short_ff <= short_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_average    = avg_ff;
   assign rsp_end_of_run = eor_ff;
   assign rsp_too_short  = short_ff;

   // A waiting beat is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !cmd.pop |-> !cmd.accept && !cmd.flush_step)
      else $error("output beat overwritten while stalled");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_W'(WINDOW))
      else $error("sample count beyond window");

   // Flush only runs on a full window
   a_flush_full: assert property (@(posedge clock) disable iff (reset)
      cmd.flush_step |-> seen_ff == CNT_W'(WINDOW))
      else $error("flush step without a full window");

endmodule

// File: rtl/circular_window_average.sv
// Latency: a result beat is registered and appears in the cycle after the sample that causes it.
// Throughput: one sample per cycle while the result side keeps up.
// The last sample of a full vector is followed by WINDOW-1 (9) wrapped results,
// issued one a cycle from the head store while the result side keeps up; no sample is taken then.
// Reset (synchronous, active high) clears the window, sum, counts and the
// output beat; the head store is not cleared.
module circular_window_average (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cwa_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                          req_final_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cwa_pkg::SAMPLE_W-1:0]  rsp_average,
   output logic                          rsp_end_of_run,
   output logic                          rsp_too_short
);
   import cwa_pkg::*;

   cmd_type    cmd;
   status_type status;

   cwa_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_final_sample (req_final_sample),
      .rsp_stall        (rsp_stall),
      .status           (status),
      .cmd              (cmd),
      .req_stall        (req_stall)
   );

   cwa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_sample       (req_sample),
      .req_final_sample (req_final_sample),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_average      (rsp_average),
      .rsp_end_of_run   (rsp_end_of_run),
      .rsp_too_short    (rsp_too_short)
   );

   // Short vector gives a flagged beat on the next cycle
   a_short_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_final_sample && !status.seen_hi
      |=> rsp_valid && rsp_too_short && rsp_end_of_run)
      else $error("short vector beat missing");

endmodule

// File: tb/circular_window_average_tb.sv
`timescale 1ns / 1ps

module circular_window_average_tb;

   import cwa_pkg::*;

   localparam int IDLE_LIMIT  = 2000;  // cycles with no beat on either side
   localparam int LONG_HOLD   = 150;   // output hold-off for the pressure test
   localparam int RANDOM_BEATS = 220;  // random samples after the directed part
   localparam int DRAIN_WAIT  = 16;    // allowance for the registered result plus the nine-beat flush

   // Sample content of one random vector
   typedef enum int {
      FILL_FULL_RANGE,
      FILL_EXTREMES,
      FILL_LOW,
      FILL_HIGH
   } fill_mode_type;

   // One expected output beat
   typedef struct packed {
      logic [SAMPLE_W-1:0] average;
      logic                end_of_run;
      logic                too_short;
   } window_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                req_final_sample = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0] rsp_average;
   logic                rsp_end_of_run;
   logic                rsp_too_short;

   // Predictor state: mirror of the window, sum, count and head store
   logic [SAMPLE_W-1:0] win_line [WINDOW];
   logic [SAMPLE_W-1:0] head_mem [WINDOW-1];
   logic [SUM_W-1:0]    win_sum;
   int unsigned         seen_in_vector;
   window_result_type   pending_averages [$];

   // Run controls and counters
   int send_gap_max = 0;
   int recv_gap_max = 0;
   int hold_request = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;
   int samples_sent = 0;
   int samples_taken = 0;
   int beats_checked = 0;
   int vectors_sent = 0;
   int short_vectors = 0;

   circular_window_average u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_final_sample (req_final_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_average      (rsp_average),
      .rsp_end_of_run   (rsp_end_of_run),
      .rsp_too_short    (rsp_too_short)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   task automatic clear_window();
      for (int k = 0; k < WINDOW; k++) win_line[k] = '0;
      win_sum = '0;
      seen_in_vector = 0;
   endtask

   task automatic push_average(input logic [SAMPLE_W-1:0] avg, input logic eor,
                               input logic shortf);
      window_result_type r;
      r.average    = avg;
      r.end_of_run = eor;
      r.too_short  = shortf;
      pending_averages.push_back(r);
   endtask

   task automatic predict_averages(input logic [SAMPLE_W-1:0] s, input logic last);
      logic [SAMPLE_W-1:0] oldest;
      logic [SUM_W-1:0]    wrap_sum;
      oldest = win_line[0];
      for (int k = 0; k < WINDOW - 1; k++) win_line[k] = win_line[k + 1];
      win_line[WINDOW-1] = s;
      win_sum = win_sum - oldest + s;   // wraps at SUM_W like the hardware sum

      if (seen_in_vector < WINDOW - 1) head_mem[seen_in_vector] = s;
      if (seen_in_vector < WINDOW) seen_in_vector++;

      // ordinary window ending on this sample
      if (seen_in_vector == WINDOW)
         push_average(SAMPLE_W'(win_sum / WINDOW), 1'b0, 1'b0);

      if (last) begin
         if (seen_in_vector < WINDOW) begin
            push_average('0, 1'b1, 1'b1);
         end else begin
            // wrapped windows: swap oldest line entries for head samples
            wrap_sum = win_sum;
            for (int k = 0; k < WINDOW - 1; k++) begin
               wrap_sum = wrap_sum - win_line[k] + head_mem[k];
               push_average(SAMPLE_W'(wrap_sum / WINDOW), (k == WINDOW - 2), 1'b0);
            end
         end
         clear_window();
      end
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic check_average_beat();
      window_result_type exp_r;
      if (pending_averages.size() == 0) begin
         note_mismatch($sformatf("unexpected beat avg=%0d eor=%0b short=%0b",
                                 rsp_average, rsp_end_of_run, rsp_too_short));
      end else begin
         exp_r = pending_averages.pop_front();
         if (rsp_average !== exp_r.average || rsp_end_of_run !== exp_r.end_of_run ||
             rsp_too_short !== exp_r.too_short)
            note_mismatch($sformatf(
               "beat %0d expected avg=%0d eor=%0b short=%0b, got avg=%0d eor=%0b short=%0b",
               beats_checked, exp_r.average, exp_r.end_of_run, exp_r.too_short,
               rsp_average, rsp_end_of_run, rsp_too_short));
      end
      beats_checked++;
   endtask

   // Both channels sampled at the edge; watchdog on beat-free stretches
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_averages(req_sample, req_final_sample);
         samples_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) check_average_beat();

      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Output side: random stall before each beat, long hold on request
   // ------------------------------------------------------------------
   initial begin
      int n;
      forever begin
         if (hold_request > 0) begin
            n = hold_request;
            hold_request = 0;
         end else begin
            n = $urandom_range(0, recv_gap_max);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid && hold_request == 0) @(posedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------
   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic last);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample       <= s;
      req_final_sample <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
      if (last) vectors_sent++;
   endtask

   function automatic logic [SAMPLE_W-1:0] draw_sample(input fill_mode_type mode);
      case (mode)
         FILL_EXTREMES: return $urandom_range(0, 1) ? {SAMPLE_W{1'b1}} : {SAMPLE_W{1'b0}};
         FILL_LOW:      return SAMPLE_W'($urandom_range(0, 15));
         FILL_HIGH:     return SAMPLE_W'($urandom_range(65520, 65535));
         default:       return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_random_vector(input int len);
      fill_mode_type mode;
      mode = fill_mode_type'($urandom_range(0, 3));
      if (len < WINDOW) short_vectors++;
      for (int i = 0; i < len; i++) send_sample(draw_sample(mode), (i == len - 1));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // vectors shorter than the window: one flagged beat each
   task automatic test_short_vectors();
      send_gap_max = 0;
      recv_gap_max = 0;
      send_sample({SAMPLE_W{1'b1}}, 1'b1);
      short_vectors++;
      for (int i = 0; i < WINDOW - 1; i++)
         send_sample(i[0] ? {SAMPLE_W{1'b1}} : {SAMPLE_W{1'b0}}, (i == WINDOW - 2));
      short_vectors++;
   endtask

   // exactly one window of full-scale samples: largest sum, full flush
   task automatic test_full_scale_window();
      for (int i = 0; i < WINDOW; i++) send_sample({SAMPLE_W{1'b1}}, (i == WINDOW - 1));
   endtask

   // output held off while samples keep coming, so the input must stall
   task automatic test_output_hold();
      send_gap_max = 0;
      recv_gap_max = 0;
      hold_request = LONG_HOLD;
      send_random_vector(30);
   endtask

   // random vectors under four idling mixes
   task automatic test_random_vectors();
      int start_count;
      int len;
      int pick;
      start_count = samples_sent;
      while (samples_sent - start_count < RANDOM_BEATS) begin
         case (((samples_sent - start_count) * 4) / RANDOM_BEATS)
            0:       begin send_gap_max = 0; recv_gap_max = 0; end
            1:       begin send_gap_max = 8; recv_gap_max = 8; end
            2:       begin send_gap_max = 0; recv_gap_max = 8; end
            default: begin send_gap_max = 8; recv_gap_max = 0; end
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 25)      len = $urandom_range(1, WINDOW - 1);
         else if (pick < 85) len = $urandom_range(WINDOW, 2 * WINDOW);
         else                len = $urandom_range(2 * WINDOW + 1, 4 * WINDOW);
         send_random_vector(len);
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      clear_window();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_vectors();
      test_full_scale_window();
      test_output_hold();
      test_random_vectors();
      req_valid <= 1'b0;

      // drain, then allow for any trailing beat
      while (pending_averages.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (pending_averages.size() != 0)
         note_mismatch($sformatf("%0d expected beats never arrived",
                                 pending_averages.size()));

      $display("covered %0d vectors (%0d shorter than the window), %0d samples taken",
               vectors_sent, short_vectors, samples_taken);
      $display("checked %0d result beats with %0d mismatches, output hold of %0d cycles",
               beats_checked, mismatch_count, LONG_HOLD);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
